// File: rtl/core/wcmv_pkg.sv
// Package for the windowed count mode vote core.
// Holds the field widths, register and operation codes, the control state type
// and the control struct that the top level hands to each histogram cell.
package wcmv_pkg;

  // Payload and register widths.
  localparam int HEIGHT_W    = 12;
  localparam int COUNT_W     = 4;
  localparam int WINDOW_W    = 8;
  localparam int CFG_DATA_W  = 12;
  localparam int CFG_INDEX_W = 1;

  // Histogram bins saturate instead of wrapping.
  localparam int             BIN_W   = 9;
  localparam logic [BIN_W-1:0] BIN_MAX = 9'd511;

  // Default bin count of the histogram.
  localparam int NUM_BINS_DEF = 16;

  // Largest tip count that a bin can stand for.
  localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;

  // Register reset values.
  localparam logic [HEIGHT_W-1:0] HEIGHT_LIMIT_RESET  = 12'd0;
  localparam logic [WINDOW_W-1:0] WINDOW_FRAMES_RESET = 8'd10;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT_LIMIT  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_FRAMES = 1'b1;

  // Item operation codes.
  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Control sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Per-cell histogram command.
  typedef struct packed {
    logic clear;
    logic inc;
  } cell_ctrl_t;

endpackage

// File: rtl/core/wcmv_cell.sv
// One histogram cell of the windowed count mode vote core.
// Holds one saturating bin and one stage of the mode search chain; uses wcmv_pkg.
module wcmv_cell #(
  parameter int IDX_W    = 4,
  parameter int CELL_IDX = 0
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  wcmv_pkg::cell_ctrl_t        ctrl,
  input  logic                        tok_in_valid,
  input  logic [wcmv_pkg::BIN_W-1:0]  tok_in_freq,
  input  logic [IDX_W-1:0]            tok_in_idx,
  output logic                        tok_out_valid,
  output logic [wcmv_pkg::BIN_W-1:0]  tok_out_freq,
  output logic [IDX_W-1:0]            tok_out_idx
);
  import wcmv_pkg::*;

  logic [BIN_W-1:0] count_r, count_nxt;
  logic             tok_valid_r;
  logic [BIN_W-1:0] tok_freq_r, tok_freq_nxt;
  logic [IDX_W-1:0] tok_idx_r, tok_idx_nxt;

  always_comb begin
    count_nxt = count_r;
    if (ctrl.clear) begin
      count_nxt = '0;
    end else if (ctrl.inc && (count_r != BIN_MAX)) begin
      count_nxt = count_r + 1'b1;
    end
  end

  // Strictly greater wins, so the lower bin keeps a tie. The token can reach
  // the first cell in the same cycle as the closing frame's increment, so the
  // bin is compared with its updated value.
  always_comb begin
    tok_freq_nxt = tok_in_freq;
    tok_idx_nxt  = tok_in_idx;
    if (count_nxt > tok_in_freq) begin
      tok_freq_nxt = count_nxt;
      tok_idx_nxt  = IDX_W'(CELL_IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      tok_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      tok_valid_r <= tok_in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_in_valid) begin
      tok_freq_r <= tok_freq_nxt;
      tok_idx_r  <= tok_idx_nxt;
    end
  end

  assign tok_out_valid = tok_valid_r;
  assign tok_out_freq  = tok_freq_r;
  assign tok_out_idx   = tok_idx_r;

endmodule

// File: rtl/core/windowed_count_mode_vote_core.sv
// Top level of the windowed count mode vote core.
// Instantiates the row of wcmv_cell histogram cells and the control sequencer;
// uses wcmv_pkg for widths, codes and types.
//
//   Channel  Direction  Handshake             Payload
//   in_      input      in_valid / in_stall   in_operation, in_box_height, in_tip_count
//   out_     output     out_valid / out_stall out_vote_valid, out_voted_count
//   cfg_     input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// An item that does not close a window is accepted in the idle state, and
// its result is loaded into the output register from the done state.
// An item that closes a window passes through the scan state, held there by the search
// token that walks the row of cells one cell per clock.
// Reset clears every bin and the frame counter and loads both configuration registers with their reset values.
// A stalled output holds the sequencer in its final state; no item is
// accepted until that result can move into the output register.
module windowed_count_mode_vote_core #(
  parameter int NUM_BINS = wcmv_pkg::NUM_BINS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input item channel.
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_operation,
  input  logic [wcmv_pkg::HEIGHT_W-1:0]     in_box_height,
  input  logic [wcmv_pkg::COUNT_W-1:0]      in_tip_count,
  // Result item channel.
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_vote_valid,
  output logic [wcmv_pkg::COUNT_W-1:0]      out_voted_count,
  // Configuration write channel.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [wcmv_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [wcmv_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import wcmv_pkg::*;

  localparam int IDX_W = $clog2(NUM_BINS);
  // Tip counts above the last usable bin fold into it.
  localparam int TopBin = ((NUM_BINS - 1) < 15) ? (NUM_BINS - 1) : 15;

  // Configuration registers.
  logic [HEIGHT_W-1:0] height_limit_r;
  logic [WINDOW_W-1:0] window_frames_r;

  // Sequencer and window state.
  state_t              state_r, state_nxt;
  logic [WINDOW_W-1:0] frames_seen_r, frames_seen_nxt;
  logic                pend_vote_r, pend_vote_nxt;
  logic [COUNT_W-1:0]  pend_count_r, pend_count_nxt;

  // Output register.
  logic                out_valid_r, out_valid_nxt;
  logic                out_vote_valid_r, out_vote_valid_nxt;
  logic [COUNT_W-1:0]  out_voted_count_r, out_voted_count_nxt;

  // Cell commands and the search token chain. Position zero feeds the first
  // cell; position NUM_BINS is the output of the last cell.
  logic                hist_clear;
  logic                hist_inc;
  logic                scan_start;
  logic [IDX_W-1:0]    bin_sel;
  cell_ctrl_t          cell_ctrl [NUM_BINS];
  logic [NUM_BINS:0]   tok_valid;
  logic [BIN_W-1:0]    tok_freq [NUM_BINS+1];
  logic [IDX_W-1:0]    tok_idx  [NUM_BINS+1];

  logic in_accept;
  logic out_free;

  // Items are taken only while the sequencer is idle.
  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // The block can always take a register write.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      height_limit_r  <= HEIGHT_LIMIT_RESET;
      window_frames_r <= WINDOW_FRAMES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_HEIGHT_LIMIT:  height_limit_r  <= cfg_data[HEIGHT_W-1:0];
        REG_WINDOW_FRAMES: window_frames_r <= cfg_data[WINDOW_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate the tip count to the last bin.
  always_comb begin
    if (in_tip_count > COUNT_W'(TopBin)) begin
      bin_sel = IDX_W'(TopBin);
    end else begin
      bin_sel = IDX_W'(in_tip_count);
    end
  end

  // Sequencer: an accepted item either finishes at once or launches the
  // mode search; the result then waits in the final state for the output
  // register to be free.
  always_comb begin
    state_nxt           = state_r;
    frames_seen_nxt     = frames_seen_r;
    pend_vote_nxt       = pend_vote_r;
    pend_count_nxt      = pend_count_r;
    out_valid_nxt       = out_valid_r && out_stall;
    out_vote_valid_nxt  = out_vote_valid_r;
    out_voted_count_nxt = out_voted_count_r;
    hist_clear          = 1'b0;
    hist_inc            = 1'b0;
    scan_start          = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          pend_vote_nxt  = 1'b0;
          pend_count_nxt = '0;
          state_nxt      = ST_DONE;
          if (in_operation == OP_CLEAR) begin
            hist_clear      = 1'b1;
            frames_seen_nxt = '0;
          end else if (in_box_height > height_limit_r) begin
            hist_inc = 1'b1;
            if (frames_seen_r >= window_frames_r) begin
              // This frame closes the window: search once the bin is counted.
              scan_start      = 1'b1;
              frames_seen_nxt = '0;
              state_nxt       = ST_SCAN;
            end else begin
              frames_seen_nxt = frames_seen_r + 1'b1;
            end
          end
        end
      end
      ST_SCAN: begin
        if (tok_valid[NUM_BINS]) begin
          // The token has passed every cell; the window is done with.
          pend_vote_nxt  = 1'b1;
          pend_count_nxt = COUNT_W'(tok_idx[NUM_BINS]);
          hist_clear     = 1'b1;
          state_nxt      = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt       = 1'b1;
          out_vote_valid_nxt  = pend_vote_r;
          out_voted_count_nxt = pend_count_r;
          state_nxt           = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      frames_seen_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      frames_seen_r <= frames_seen_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_vote_r       <= pend_vote_nxt;
    pend_count_r      <= pend_count_nxt;
    out_vote_valid_r  <= out_vote_valid_nxt;
    out_voted_count_r <= out_voted_count_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_vote_valid  = out_vote_valid_r;
  assign out_voted_count = out_voted_count_r;

  // The search enters the row with an empty best so far.
  assign tok_valid[0] = scan_start;
  assign tok_freq[0]  = '0;
  assign tok_idx[0]   = '0;

  // Row of histogram cells. Each cell owns one bin and passes the running
  // best (count, bin) to its right neighbor each clock.
  for (genvar i = 0; i < NUM_BINS; i++) begin : g_cell
    assign cell_ctrl[i].clear = hist_clear;
    assign cell_ctrl[i].inc   = hist_inc && (bin_sel == IDX_W'(i));

    wcmv_cell #(
      .IDX_W    (IDX_W),
      .CELL_IDX (i)
    ) u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .ctrl          (cell_ctrl[i]),
      .tok_in_valid  (tok_valid[i]),
      .tok_in_freq   (tok_freq[i]),
      .tok_in_idx    (tok_idx[i]),
      .tok_out_valid (tok_valid[i+1]),
      .tok_out_freq  (tok_freq[i+1]),
      .tok_out_idx   (tok_idx[i+1])
    );
  end

`ifndef SYNTHESIS
  // Only one search is ever in flight along the row.
  a_single_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_valid))
    else $error("more than one search token in the cell row");

  // A token leaving the first or the last cell is seen only while the sequencer waits for it.
  a_token_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (tok_valid[NUM_BINS] || tok_valid[1]) |-> (state_r == ST_SCAN))
    else $error("search token outside the scan state");

  // A closed window restarts its frame count before the search runs.
  a_scan_counter: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (frames_seen_r == '0))
    else $error("frame counter not cleared during the search");

  // An accepted item always leaves the idle state.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r != ST_IDLE))
    else $error("sequencer idle right after an accepted item");
`endif

endmodule
